@@ hw/rtl/tebc_pkg.sv @@
// Shared op codes and controller-to-datapath command type.
package tebc_pkg;

    localparam int OP_W = 2;

    localparam logic [OP_W-1:0] OP_RX     = 2'd0;
    localparam logic [OP_W-1:0] OP_TXDONE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the incoming transaction
        logic exec;     // update pointers and access the stores
        logic load;     // move the finished result into the output register
    } t_cmd;

endpackage

@@ hw/rtl/terminal_echo_buffer_controller.sv @@
// Top level: terminal character buffering with echo, controller plus datapath.
//
// Usage
//   Input channel (i_in_valid / o_in_ready) carries one event transaction:
//   i_op selects received byte, transmit done or read of the input buffer,
//   i_terminal picks the terminal, i_rx_byte is the received character.
//   Output channel (o_out_valid / i_out_ready) returns exactly one result
//   transaction per event: echo to transmitter, stored/queued/dropped flags,
//   and the byte popped by a read. Fields not belonging to the op are zero.
// Timing
//   Accept, execute (pointer update plus at most one access to each byte
//   store), finish. Each event does a single read-modify-write of the selected
//   terminal's pointer set; the next event is accepted no earlier than the
//   finish step of the one before, in which its result is loaded.
// Reset
//   Synchronous, active low. Counts, ring pointers and busy flags clear at
//   once; the byte stores are not cleared, since every read is gated by count.
// Stall
//   While a result waits for i_out_ready, one more event is accepted and
//   executed; it then holds in the finish step until the output frees up.
module terminal_echo_buffer_controller #(
    parameter int NUM_TERMINALS = 4,
    parameter int INPUT_DEPTH   = 256,
    parameter int ECHO_DEPTH    = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_op,
    input  logic [1:0] i_terminal,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_tx_valid,
    output logic [7:0] o_tx_byte,
    output logic       o_stored,
    output logic       o_echo_queued,
    output logic       o_echo_dropped,
    output logic       o_read_valid,
    output logic [7:0] o_read_byte
);

    tebc_pkg::t_cmd w_cmd;

    // sequencing
    tebc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    // per-terminal state, stores and result register
    tebc_dpath #(
        .NUM_TERMINALS (NUM_TERMINALS),
        .INPUT_DEPTH   (INPUT_DEPTH),
        .ECHO_DEPTH    (ECHO_DEPTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_op           (i_op),
        .i_terminal     (i_terminal),
        .i_rx_byte      (i_rx_byte),
        .o_tx_valid     (o_tx_valid),
        .o_tx_byte      (o_tx_byte),
        .o_stored       (o_stored),
        .o_echo_queued  (o_echo_queued),
        .o_echo_dropped (o_echo_dropped),
        .o_read_valid   (o_read_valid),
        .o_read_byte    (o_read_byte)
    );

    // An echo is only queued or dropped for a byte that was stored.
    a_echo_needs_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_echo_queued || o_echo_dropped)) |-> o_stored)
        else $error("echo outcome without stored byte");

    // A stored byte either goes out directly or meets the echo buffer, never both.
    a_echo_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_tx_valid && (o_echo_queued || o_echo_dropped))
                        && !(o_echo_queued && o_echo_dropped))
        else $error("conflicting echo outcomes");

    // A read result never coincides with receive or transmit results.
    a_read_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_read_valid) |-> !(o_stored || o_tx_valid))
        else $error("read result mixed with other op");

    // Empty read returns zero byte.
    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_read_valid) |-> (o_read_byte == 8'd0))
        else $error("nonzero byte on empty read");

endmodule

@@ hw/rtl/tebc_ctrl.sv @@
// Sequencing state machine: accept, execute, finish.
module tebc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output tebc_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIN
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_can_load;

    assign w_can_load  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) || ((r_state == S_FIN) && w_can_load);
    assign o_out_valid = r_out_valid;

    assign o_cmd.capture = i_in_valid && o_in_ready;
    assign o_cmd.exec    = (r_state == S_EXEC);
    assign o_cmd.load    = (r_state == S_FIN) && w_can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.capture) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (o_cmd.load) begin
                        r_state <= o_cmd.capture ? S_EXEC : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/tebc_dpath.sv @@
// Per-terminal ring pointers, byte stores and result register.
module tebc_dpath #(
    parameter int NUM_TERMINALS = 4,
    parameter int INPUT_DEPTH   = 256,
    parameter int ECHO_DEPTH    = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tebc_pkg::t_cmd               i_cmd,
    input  logic [tebc_pkg::OP_W-1:0]    i_op,
    input  logic [1:0]                   i_terminal,
    input  logic [7:0]                   i_rx_byte,
    output logic                         o_tx_valid,
    output logic [7:0]                   o_tx_byte,
    output logic                         o_stored,
    output logic                         o_echo_queued,
    output logic                         o_echo_dropped,
    output logic                         o_read_valid,
    output logic [7:0]                   o_read_byte
);

    localparam int TW  = (NUM_TERMINALS > 1) ? $clog2(NUM_TERMINALS) : 1;
    localparam int IW  = $clog2(INPUT_DEPTH);
    localparam int EW  = $clog2(ECHO_DEPTH);
    localparam int ICW = $clog2(INPUT_DEPTH + 1);
    localparam int ECW = $clog2(ECHO_DEPTH + 1);
    localparam int IMEM_DEPTH = (2 ** TW) * (2 ** IW);
    localparam int EMEM_DEPTH = (2 ** TW) * (2 ** EW);

    // captured transaction
    logic [tebc_pkg::OP_W-1:0] r_op;
    logic [1:0]                r_term;
    logic [7:0]                r_byte;

    // per-terminal control state
    logic [ICW-1:0] r_in_cnt   [NUM_TERMINALS];
    logic [IW-1:0]  r_in_head  [NUM_TERMINALS];
    logic [IW-1:0]  r_in_tail  [NUM_TERMINALS];
    logic [ECW-1:0] r_ec_cnt   [NUM_TERMINALS];
    logic [EW-1:0]  r_ec_head  [NUM_TERMINALS];
    logic [EW-1:0]  r_ec_tail  [NUM_TERMINALS];
    logic           r_busy     [NUM_TERMINALS];

    // byte stores
    logic [7:0] r_in_mem [IMEM_DEPTH];
    logic [7:0] r_ec_mem [EMEM_DEPTH];
    logic [7:0] r_in_rd;
    logic [7:0] r_ec_rd;

    // pending result flags between execute and load
    logic r_p_tx_valid, r_p_tx_mem, r_p_stored, r_p_queued, r_p_dropped, r_p_read;

    logic [TW-1:0]  w_t;
    logic           w_term_ok;
    logic [ICW-1:0] w_in_cnt;
    logic [IW-1:0]  w_in_head, w_in_tail;
    logic [ECW-1:0] w_ec_cnt;
    logic [EW-1:0]  w_ec_head, w_ec_tail;
    logic           w_busy;
    logic           w_in_full, w_in_empty, w_ec_full, w_ec_empty;

    // decisions for this transaction
    logic n_in_push, n_in_pop, n_ec_push, n_ec_pop, n_tx_direct;
    logic n_busy;

    assign w_t       = TW'(r_term);
    assign w_term_ok = (32'(r_term) < NUM_TERMINALS);

    always_comb begin
        w_in_cnt  = '0;
        w_in_head = '0;
        w_in_tail = '0;
        w_ec_cnt  = '0;
        w_ec_head = '0;
        w_ec_tail = '0;
        w_busy    = 1'b0;
        if (w_term_ok) begin
            w_in_cnt  = r_in_cnt[w_t];
            w_in_head = r_in_head[w_t];
            w_in_tail = r_in_tail[w_t];
            w_ec_cnt  = r_ec_cnt[w_t];
            w_ec_head = r_ec_head[w_t];
            w_ec_tail = r_ec_tail[w_t];
            w_busy    = r_busy[w_t];
        end
    end

    assign w_in_full  = (w_in_cnt == ICW'(INPUT_DEPTH));
    assign w_in_empty = (w_in_cnt == '0);
    assign w_ec_full  = (w_ec_cnt == ECW'(ECHO_DEPTH));
    assign w_ec_empty = (w_ec_cnt == '0);

    always_comb begin
        n_in_push   = 1'b0;
        n_in_pop    = 1'b0;
        n_ec_push   = 1'b0;
        n_ec_pop    = 1'b0;
        n_tx_direct = 1'b0;
        n_busy      = w_busy;
        if (w_term_ok) begin
            case (r_op)
                tebc_pkg::OP_RX: begin
                    if (!w_in_full) begin
                        n_in_push = 1'b1;
                        if (w_busy) begin
                            n_ec_push = !w_ec_full;
                        end else begin
                            n_tx_direct = 1'b1;
                            n_busy      = 1'b1;
                        end
                    end
                end
                tebc_pkg::OP_TXDONE: begin
                    n_ec_pop = !w_ec_empty;
                    n_busy   = !w_ec_empty;
                end
                tebc_pkg::OP_READ: begin
                    n_in_pop = !w_in_empty;
                end
                default: begin
                    n_busy = w_busy;
                end
            endcase
        end
    end

    // capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_op;
            r_term <= i_terminal;
            r_byte <= i_rx_byte;
        end
    end

    // pointer and count update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_TERMINALS; k++) begin
                r_in_cnt[k]  <= '0;
                r_in_head[k] <= '0;
                r_in_tail[k] <= '0;
                r_ec_cnt[k]  <= '0;
                r_ec_head[k] <= '0;
                r_ec_tail[k] <= '0;
                r_busy[k]    <= 1'b0;
            end
        end else if (i_cmd.exec && w_term_ok) begin
            r_busy[w_t] <= n_busy;
            if (n_in_push) begin
                r_in_cnt[w_t]  <= w_in_cnt + 1'b1;
                r_in_tail[w_t] <= (w_in_tail == IW'(INPUT_DEPTH - 1)) ? '0 : w_in_tail + 1'b1;
            end
            if (n_in_pop) begin
                r_in_cnt[w_t]  <= w_in_cnt - 1'b1;
                r_in_head[w_t] <= (w_in_head == IW'(INPUT_DEPTH - 1)) ? '0 : w_in_head + 1'b1;
            end
            if (n_ec_push) begin
                r_ec_cnt[w_t]  <= w_ec_cnt + 1'b1;
                r_ec_tail[w_t] <= (w_ec_tail == EW'(ECHO_DEPTH - 1)) ? '0 : w_ec_tail + 1'b1;
            end
            if (n_ec_pop) begin
                r_ec_cnt[w_t]  <= w_ec_cnt - 1'b1;
                r_ec_head[w_t] <= (w_ec_head == EW'(ECHO_DEPTH - 1)) ? '0 : w_ec_head + 1'b1;
            end
        end
    end

    // input store: one write or one registered read per transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && n_in_push) begin
            r_in_mem[{w_t, w_in_tail}] <= r_byte;
        end
        if (i_cmd.exec && n_in_pop) begin
            r_in_rd <= r_in_mem[{w_t, w_in_head}];
        end
    end

    // echo store
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && n_ec_push) begin
            r_ec_mem[{w_t, w_ec_tail}] <= r_byte;
        end
        if (i_cmd.exec && n_ec_pop) begin
            r_ec_rd <= r_ec_mem[{w_t, w_ec_head}];
        end
    end

    // pending flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_p_tx_valid <= n_tx_direct || n_ec_pop;
            r_p_tx_mem   <= n_ec_pop;
            r_p_stored   <= n_in_push;
            r_p_queued   <= n_ec_push;
            r_p_dropped  <= n_in_push && w_busy && !n_ec_push;
            r_p_read     <= n_in_pop;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_tx_valid     <= r_p_tx_valid;
            o_tx_byte      <= r_p_tx_mem ? r_ec_rd : (r_p_tx_valid ? r_byte : 8'd0);
            o_stored       <= r_p_stored;
            o_echo_queued  <= r_p_queued;
            o_echo_dropped <= r_p_dropped;
            o_read_valid   <= r_p_read;
            o_read_byte    <= r_p_read ? r_in_rd : 8'd0;
        end
    end

endmodule

@@ dv/terminal_echo_checker.sv @@
// Channel monitor with its own terminal-buffer predictor and result comparison.
module terminal_echo_checker #(
    parameter int NUM_TERMINALS = 4,
    parameter int INPUT_DEPTH   = 256,
    parameter int ECHO_DEPTH    = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [1:0] i_op,
    input  logic [1:0] i_terminal,
    input  logic [7:0] i_rx_byte,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic       i_tx_valid,
    input  logic [7:0] i_tx_byte,
    input  logic       i_stored,
    input  logic       i_echo_queued,
    input  logic       i_echo_dropped,
    input  logic       i_read_valid,
    input  logic [7:0] i_read_byte,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       stored;
        logic       echo_queued;
        logic       echo_dropped;
        logic       read_valid;
        logic [7:0] read_byte;
    } t_event_result;

    // Per-terminal rings: fill level, read index, write index.
    logic [7:0]  input_ring [NUM_TERMINALS][INPUT_DEPTH];
    int unsigned input_fill [NUM_TERMINALS];
    int unsigned input_rd   [NUM_TERMINALS];
    int unsigned input_wr   [NUM_TERMINALS];
    logic [7:0]  echo_ring  [NUM_TERMINALS][ECHO_DEPTH];
    int unsigned echo_fill  [NUM_TERMINALS];
    int unsigned echo_rd    [NUM_TERMINALS];
    int unsigned echo_wr    [NUM_TERMINALS];
    bit          tx_active  [NUM_TERMINALS];

    t_event_result expected_results [$];
    int            mismatch_count = 0;

    function automatic t_event_result predict_event(logic [1:0] op, logic [1:0] term,
                                                    logic [7:0] rx);
        t_event_result res;
        int            t;
        res = '0;
        t   = term;
        if (t >= NUM_TERMINALS) return res;
        case (op)
            tebc_pkg::OP_RX: begin
                // Full input ring: byte is lost and not echoed.
                if (input_fill[t] < INPUT_DEPTH) begin
                    input_ring[t][input_wr[t]] = rx;
                    input_wr[t] = (input_wr[t] == INPUT_DEPTH - 1) ? 0 : input_wr[t] + 1;
                    input_fill[t]++;
                    res.stored = 1'b1;
                    if (!tx_active[t]) begin
                        res.tx_valid = 1'b1;
                        res.tx_byte  = rx;
                        tx_active[t] = 1'b1;
                    end else if (echo_fill[t] < ECHO_DEPTH) begin
                        echo_ring[t][echo_wr[t]] = rx;
                        echo_wr[t] = (echo_wr[t] == ECHO_DEPTH - 1) ? 0 : echo_wr[t] + 1;
                        echo_fill[t]++;
                        res.echo_queued = 1'b1;
                    end else begin
                        res.echo_dropped = 1'b1;
                    end
                end
            end
            tebc_pkg::OP_TXDONE: begin
                // Clears busy even when idle; a queued echo still goes out.
                tx_active[t] = 1'b0;
                if (echo_fill[t] != 0) begin
                    res.tx_valid = 1'b1;
                    res.tx_byte  = echo_ring[t][echo_rd[t]];
                    echo_rd[t]   = (echo_rd[t] == ECHO_DEPTH - 1) ? 0 : echo_rd[t] + 1;
                    echo_fill[t]--;
                    tx_active[t] = 1'b1;
                end
            end
            tebc_pkg::OP_READ: begin
                if (input_fill[t] != 0) begin
                    res.read_valid = 1'b1;
                    res.read_byte  = input_ring[t][input_rd[t]];
                    input_rd[t] = (input_rd[t] == INPUT_DEPTH - 1) ? 0 : input_rd[t] + 1;
                    input_fill[t]--;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        mismatch_count++;
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    task automatic compare_field(string what, logic [7:0] got, logic [7:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    // Sampled at the edge, so both sides see pre-edge values.
    always @(posedge i_clk) begin
        t_event_result got;
        t_event_result want;
        if (!i_rst_n) begin
            for (int t = 0; t < NUM_TERMINALS; t++) begin
                input_fill[t] = 0;
                input_rd[t]   = 0;
                input_wr[t]   = 0;
                echo_fill[t]  = 0;
                echo_rd[t]    = 0;
                echo_wr[t]    = 0;
                tx_active[t]  = 1'b0;
            end
            expected_results.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                expected_results.push_back(predict_event(i_op, i_terminal, i_rx_byte));
            if (i_out_valid && i_out_ready) begin
                got = '{tx_valid: i_tx_valid, tx_byte: i_tx_byte, stored: i_stored,
                        echo_queued: i_echo_queued, echo_dropped: i_echo_dropped,
                        read_valid: i_read_valid, read_byte: i_read_byte};
                if (expected_results.size() == 0) begin
                    report_mismatch("result transaction with none outstanding", 8'd1, 8'd0);
                end else begin
                    want = expected_results.pop_front();
                    compare_field("tx_valid", got.tx_valid, want.tx_valid);
                    compare_field("tx_byte", got.tx_byte, want.tx_byte);
                    compare_field("stored", got.stored, want.stored);
                    compare_field("echo_queued", got.echo_queued, want.echo_queued);
                    compare_field("echo_dropped", got.echo_dropped, want.echo_dropped);
                    compare_field("read_valid", got.read_valid, want.read_valid);
                    compare_field("read_byte", got.read_byte, want.read_byte);
                end
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= mismatch_count;
    end

endmodule

@@ dv/tb_terminal_echo_buffer_controller.sv @@
// Testbench top: event stimulus, result back-pressure, hang watchdog and verdict.
module tb_terminal_echo_buffer_controller;

    localparam int TERMINALS     = 4;
    localparam int INPUT_DEPTH   = 256;
    localparam int ECHO_DEPTH    = 256;
    localparam int FILL_TERMINAL = 2;    // given only the ignored op by the directed part
    localparam int RANDOM_EVENTS = 130;
    localparam int DRAIN_CYCLES  = 8;    // margin after the outstanding results are back
    localparam int HANG_LIMIT    = 2000; // cycles with no transaction on either side

    // Op code the block must ignore.
    localparam logic [tebc_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [1:0] i_op        = tebc_pkg::OP_READ;
    logic [1:0] i_terminal  = 2'd0;
    logic [7:0] i_rx_byte   = 8'd0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic       o_tx_valid;
    logic [7:0] o_tx_byte;
    logic       o_stored;
    logic       o_echo_queued;
    logic       o_echo_dropped;
    logic       o_read_valid;
    logic [7:0] o_read_byte;

    int fail_count;
    int pending;
    bit no_gaps     = 1'b0; // both sides run back to back while set
    int idle_cycles = 0;

    always #10 i_clk = ~i_clk;

    terminal_echo_buffer_controller #(
        .NUM_TERMINALS(TERMINALS),
        .INPUT_DEPTH  (INPUT_DEPTH),
        .ECHO_DEPTH   (ECHO_DEPTH)
    ) dut (.*);

    terminal_echo_checker #(
        .NUM_TERMINALS(TERMINALS),
        .INPUT_DEPTH  (INPUT_DEPTH),
        .ECHO_DEPTH   (ECHO_DEPTH)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_terminal    (i_terminal),
        .i_rx_byte     (i_rx_byte),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_tx_valid    (o_tx_valid),
        .i_tx_byte     (o_tx_byte),
        .i_stored      (o_stored),
        .i_echo_queued (o_echo_queued),
        .i_echo_dropped(o_echo_dropped),
        .i_read_valid  (o_read_valid),
        .i_read_byte   (o_read_byte),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Watchdog: any transaction on either channel restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == HANG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: hold ready low for a random stall, then keep it high
    // until one result transaction goes through.
    initial begin
        int stall;
        wait (i_rst_n);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    // One event transaction, after a random gap; returns at the accepting edge.
    task automatic send_event(logic [1:0] op, logic [1:0] term, logic [7:0] rx);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_terminal <= term;
        i_rx_byte  <= rx;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Sender holds off until every outstanding result has come back.
    // The first edge lets the outstanding count catch the last transaction.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int         pick;
        logic [1:0] op;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty read, done while idle, ignored op, zero byte,
        // echo queue and release in order, full-scale bytes.
        send_event(tebc_pkg::OP_READ,   2'd0, 8'h00);
        send_event(tebc_pkg::OP_TXDONE, 2'd1, 8'hFF);
        send_event(OP_UNUSED,           2'd2, 8'hFF);
        send_event(tebc_pkg::OP_RX,     2'd0, 8'h00);
        send_event(tebc_pkg::OP_RX,     2'd0, 8'hFF);
        send_event(tebc_pkg::OP_RX,     2'd0, 8'hA5);
        send_event(tebc_pkg::OP_TXDONE, 2'd0, 8'h00);
        send_event(tebc_pkg::OP_TXDONE, 2'd0, 8'h00);
        send_event(tebc_pkg::OP_TXDONE, 2'd0, 8'h00);
        send_event(tebc_pkg::OP_TXDONE, 2'd0, 8'h00);
        send_event(tebc_pkg::OP_READ,   2'd0, 8'h00);
        send_event(tebc_pkg::OP_READ,   2'd0, 8'h00);
        send_event(tebc_pkg::OP_READ,   2'd0, 8'h00);
        send_event(tebc_pkg::OP_READ,   2'd0, 8'h00);
        send_event(tebc_pkg::OP_RX,     2'd3, 8'h5A);
        send_event(tebc_pkg::OP_RX,     2'd1, 8'h01);
        send_event(tebc_pkg::OP_RX,     2'd1, 8'h80);
        send_event(tebc_pkg::OP_READ,   2'd3, 8'h00);
        send_event(OP_UNUSED,           2'd3, 8'h80);
        send_event(tebc_pkg::OP_TXDONE, 2'd3, 8'h00);
        send_event(tebc_pkg::OP_TXDONE, 2'd1, 8'h00);

        wait_for_results();

        // Fill one terminal: the first byte takes the transmitter, the rest
        // queue for echo until the input ring is full and one byte is refused.
        for (int n = 0; n < INPUT_DEPTH + 1; n++) begin
            no_gaps = (n >= 64 && n < 160);
            send_event(tebc_pkg::OP_RX, 2'(FILL_TERMINAL), 8'($urandom_range(0, 255)));
        end
        no_gaps = 1'b0;
        // Make room each time: the echo ring fills, then echoes are dropped.
        repeat (3) begin
            send_event(tebc_pkg::OP_READ, 2'(FILL_TERMINAL), 8'($urandom_range(0, 255)));
            send_event(tebc_pkg::OP_RX, 2'(FILL_TERMINAL), 8'($urandom_range(0, 255)));
        end
        repeat (40)
            send_event($urandom_range(0, 1) ? tebc_pkg::OP_READ : tebc_pkg::OP_TXDONE,
                       2'(FILL_TERMINAL), 8'($urandom_range(0, 255)));

        // Random mix over all terminals, with a back-to-back stretch.
        for (int n = 0; n < RANDOM_EVENTS; n++) begin
            no_gaps = (n >= 60 && n < 100);
            pick    = $urandom_range(0, 99);
            if (pick < 40)      op = tebc_pkg::OP_RX;
            else if (pick < 65) op = tebc_pkg::OP_TXDONE;
            else if (pick < 95) op = tebc_pkg::OP_READ;
            else                op = OP_UNUSED;
            send_event(op, 2'($urandom_range(0, TERMINALS - 1)),
                       8'($urandom_range(0, 255)));
        end
        no_gaps = 1'b0;

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/tebc_pkg.sv
hw/rtl/tebc_ctrl.sv
hw/rtl/tebc_dpath.sv
hw/rtl/terminal_echo_buffer_controller.sv
dv/terminal_echo_checker.sv
dv/tb_terminal_echo_buffer_controller.sv
